// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, held off while reset is high
`define ASSERT_CLKRST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// types and constants of the stepper position follower
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int unsigned POS_W = 16;
   localparam int unsigned COIL_W = 4;

   // item function codes
   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_MOVE    = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   localparam logic [POS_W-1:0] MAX_POSITION_RESET = 16'd2000;

   typedef struct packed {
      logic [1:0]       func;
      logic [POS_W-1:0] step_count;
      logic             move_forward;
   } req_type;

   typedef struct packed {
      logic [COIL_W-1:0] coil_drive;
      logic              at_rest;
      logic [POS_W-1:0]  position;
   } rsp_type;

   // full-step coil sequence
   function automatic logic [COIL_W-1:0] phase_coils(input logic [1:0] phase);
      logic [COIL_W-1:0] coils;
      case (phase)
         2'd0: coils = 4'h3;
         2'd1: coils = 4'h6;
         2'd2: coils = 4'hc;
         2'd3: coils = 4'h9;
         default: coils = 4'h0;
      endcase
      return coils;
   endfunction

endpackage

// File: src/spf_channels.sv
// ----------------------------------------------------------------------------
// spf channels
// valid/ready channel interfaces for command items and result items
// ----------------------------------------------------------------------------
interface spf_req_if;
   import spf_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spf_rsp_if;
   import spf_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: src/stepper_position_follower.sv
// ----------------------------------------------------------------------------
// stepper_position_follower
// full-step stepper controller that walks its position toward a target
// ----------------------------------------------------------------------------
// Command items arrive on req_chan (valid/ready): a tick, a move or a restart.
// Every item gives exactly one result item on rsp_chan holding the coil
// drive, the at-rest flag and the position after that item.
// The upper limit of the target is written through csr_wr_en/csr_wr_data;
// the user must do so while no item is in flight, not enforced here; 2000 after reset.
// Pipeline: an accepted item enters the input register, and the state update
// and the result register follow it unless the result register is stalled.
// Throughput: one item per cycle while rsp_chan is not stalled; the state
// update, with a 17-bit add and compare, lies between the two registers.
// Reset (synchronous): position and target 0, coils off, at rest, both
// pipeline registers empty.
// When the receiver stalls, the result register holds its item, the input
// register then fills and req_chan.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_position_follower (
   input  logic                     clock,
   input  logic                     reset,
   spf_req_if.sink                  req_chan,
   spf_rsp_if.source                rsp_chan,
   input  logic                     csr_wr_en,
   input  logic [spf_pkg::POS_W-1:0] csr_wr_data
);
   import spf_pkg::*;

   logic             in_valid_ff;
   req_type          in_data_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;
   logic [POS_W-1:0] max_ff;
   logic [POS_W-1:0] cur_ff, cur_in;
   logic [POS_W-1:0] tgt_ff, tgt_in;
   logic             ready_ff, ready_in;
   logic [COIL_W-1:0] coil_ff, coil_in;
   logic             advance;
   logic [POS_W:0]   fwd_sum;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign fwd_sum = {1'b0, tgt_ff} + {1'b0, in_data_ff.step_count};

   always_comb begin
      cur_in   = cur_ff;
      tgt_in   = tgt_ff;
      ready_in = ready_ff;
      coil_in  = coil_ff;
      case (in_data_ff.func)
         FUNC_TICK: begin
            if (cur_ff != tgt_ff) begin
               cur_in  = (cur_ff < tgt_ff) ? cur_ff + 1'b1 : cur_ff - 1'b1;
               coil_in = phase_coils(cur_in[1:0]);
            end else begin
               coil_in  = '0;
               ready_in = 1'b1;
            end
         end
         FUNC_MOVE: begin
            if (in_data_ff.move_forward) begin
               // sum kept at 17 bits so it cannot wrap past the limit
               tgt_in = (fwd_sum > {1'b0, max_ff}) ? max_ff : fwd_sum[POS_W-1:0];
            end else begin
               tgt_in = (in_data_ff.step_count > tgt_ff) ? '0
                        : tgt_ff - in_data_ff.step_count;
            end
            ready_in = 1'b0;
         end
         FUNC_RESTART: begin
            ready_in = 1'b0;
         end
         default: begin
         end
      endcase
      out_data_in.coil_drive = coil_in;
      out_data_in.at_rest    = ready_in;
      out_data_in.position   = cur_in;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_ff       <= MAX_POSITION_RESET;
         cur_ff       <= '0;
         tgt_ff       <= '0;
         ready_ff     <= 1'b1;
         coil_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         if (advance) begin
            cur_ff   <= cur_in;
            tgt_ff   <= tgt_in;
            ready_ff <= ready_in;
            coil_ff  <= coil_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_chan.data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   `ASSERT_CLKRST(a_rest_at_target, clock, reset, ready_ff |-> (cur_ff == tgt_ff),
      "at rest while position differs from target")
   `ASSERT_CLKRST(a_coils_two_on, clock, reset,
      ($countones(coil_ff) == 0) || ($countones(coil_ff) == 2),
      "coil pattern is not a full-step pattern")
   `ASSERT_CLKRST(a_advance_fills, clock, reset, advance |=> out_valid_ff,
      "item advanced but no result registered")
   `ASSERT_CLKRST(a_stall_holds, clock, reset,
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)),
      "stalled input register lost its item")
   `ASSERT_CLK(a_reset_empty, clock, reset |=> (!in_valid_ff && !out_valid_ff),
      "pipeline not empty after reset")

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper position follower testbench
// drives tick, move and restart items with random idling on both channels,
// predicts position, target, rest flag and coil drive in step and checks
// every result item in order, across several upper limits of the target
// ----------------------------------------------------------------------------
module tb;
   import spf_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam logic [COIL_W-1:0] FULL_STEP [4] = '{4'h3, 4'h6, 4'hc, 4'h9};

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [POS_W-1:0] csr_wr_data;

   spf_req_if req_bus ();
   spf_rsp_if rsp_bus ();

   stepper_position_follower i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // follower state as the testbench sees it
   logic [POS_W-1:0]  pos_now;
   logic [POS_W-1:0]  pos_goal;
   logic              resting;
   logic [COIL_W-1:0] coils_now;
   logic [POS_W-1:0]  goal_limit;

   req_type cmd_queue [$];
   rsp_type awaited_status [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned cycle_count;
   int unsigned mismatch_count;
   logic        req_taken;

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // state update for one accepted item, returns the status it leaves
   function automatic rsp_type follow_item(input req_type cmd);
      logic [POS_W:0] sum;
      rsp_type status;
      case (cmd.func)
         FUNC_TICK: begin
            if (pos_now != pos_goal) begin
               pos_now = (pos_now < pos_goal) ? pos_now + 1'b1 : pos_now - 1'b1;
               coils_now = FULL_STEP[pos_now[1:0]];
            end else begin
               coils_now = '0;
               resting = 1'b1;
            end
         end
         FUNC_MOVE: begin
            if (cmd.move_forward) begin
               sum = {1'b0, pos_goal} + {1'b0, cmd.step_count};
               pos_goal = (sum > {1'b0, goal_limit}) ? goal_limit : sum[POS_W-1:0];
            end else begin
               pos_goal = (cmd.step_count > pos_goal) ? '0 : pos_goal - cmd.step_count;
            end
            resting = 1'b0;
         end
         FUNC_RESTART: resting = 1'b0;
         default: ;
      endcase
      status.coil_drive = coils_now;
      status.at_rest = resting;
      status.position = pos_now;
      return status;
   endfunction

   function automatic req_type make_item(input logic [1:0] func, input logic [POS_W-1:0] steps,
                                         input logic fwd);
      req_type cmd;
      cmd.func = func;
      cmd.step_count = steps;
      cmd.move_forward = fwd;
      return cmd;
   endfunction

   function automatic req_type random_item();
      int unsigned pick;
      req_type cmd;
      pick = $urandom_range(0, 99);
      cmd.func = (pick < 55) ? FUNC_TICK : (pick < 80) ? FUNC_MOVE :
                 (pick < 90) ? FUNC_RESTART : FUNC_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         cmd.step_count = POS_W'($urandom_range(0, 65535));
      else if (pick < 16)
         cmd.step_count = '0;
      else if (pick < 20)
         cmd.step_count = '1;
      else
         cmd.step_count = POS_W'($urandom_range(0, 48));
      cmd.move_forward = 1'($urandom_range(0, 1));
      return cmd;
   endfunction

   // sender: next item only once the current one has gone
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_bus.data <= cmd_queue.pop_front();
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready)
         awaited_status.push_back(follow_item(req_bus.data));
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_status.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result item: coils %h rest %b pos %0d",
                        rsp_bus.data.coil_drive, rsp_bus.data.at_rest,
                        rsp_bus.data.position);
            mismatch_count <= mismatch_count + 1;
         end else begin
            want = awaited_status.pop_front();
            if (rsp_bus.data.coil_drive !== want.coil_drive ||
                rsp_bus.data.at_rest !== want.at_rest ||
                rsp_bus.data.position !== want.position) begin
               if (mismatch_count < 10)
                  $display("mismatch: coils %h/%h rest %b/%b pos %0d/%0d (expected/actual)",
                           want.coil_drive, rsp_bus.data.coil_drive, want.at_rest,
                           rsp_bus.data.at_rest, want.position, rsp_bus.data.position);
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   // everything sent and answered, then a settling wait for the pipeline
   task automatic drain();
      while (cmd_queue.size() != 0 || req_bus.valid || awaited_status.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [POS_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      goal_limit = value;
   endtask

   task automatic feed_random(input int unsigned count);
      repeat (count) cmd_queue.push_back(random_item());
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      rsp_bus.ready = 1'b0;
      req_taken = 1'b0;
      cycle_count = 0;
      mismatch_count = 0;
      pos_now = '0;
      pos_goal = '0;
      resting = 1'b1;
      coils_now = '0;
      goal_limit = MAX_POSITION_RESET;
      send_idle_pct = 17;
      recv_idle_pct = 57;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: rest tick, all four phases forward and two backward, saturation at both ends
      cmd_queue.push_back(make_item(FUNC_TICK, 16'd0, 1'b0));
      cmd_queue.push_back(make_item(FUNC_UNUSED, 16'd0, 1'b0));
      cmd_queue.push_back(make_item(FUNC_MOVE, 16'd5, 1'b1));
      repeat (6) cmd_queue.push_back(make_item(FUNC_TICK, 16'd0, 1'b0));
      cmd_queue.push_back(make_item(FUNC_RESTART, 16'd0, 1'b0));
      cmd_queue.push_back(make_item(FUNC_MOVE, 16'd2, 1'b0));
      repeat (2) cmd_queue.push_back(make_item(FUNC_TICK, 16'hffff, 1'b1));
      cmd_queue.push_back(make_item(FUNC_MOVE, 16'd0, 1'b1));
      cmd_queue.push_back(make_item(FUNC_MOVE, 16'd0, 1'b0));
      cmd_queue.push_back(make_item(FUNC_MOVE, 16'hffff, 1'b0));
      cmd_queue.push_back(make_item(FUNC_MOVE, 16'hffff, 1'b1));
      cmd_queue.push_back(make_item(FUNC_MOVE, 16'hffff, 1'b1));
      cmd_queue.push_back(make_item(FUNC_TICK, 16'd0, 1'b0));
      cmd_queue.push_back(make_item(FUNC_UNUSED, 16'hffff, 1'b1));
      cmd_queue.push_back(make_item(FUNC_RESTART, 16'haaaa, 1'b1));
      cmd_queue.push_back(make_item(FUNC_MOVE, 16'd1999, 1'b0));
      cmd_queue.push_back(make_item(FUNC_TICK, 16'h5555, 1'b0));
      cmd_queue.push_back(make_item(FUNC_MOVE, 16'h8000, 1'b1));

      // target left above the new limit
      write_limit(16'd300);
      feed_random(150);
      write_limit(16'hffff);
      feed_random(150);

      send_idle_pct = 57;
      recv_idle_pct = 17;
      write_limit(16'd0);
      feed_random(150);
      write_limit(16'd40);
      feed_random(100);
      // hold the sender until every result is back
      drain();
      feed_random(100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(16'd150);
      feed_random(250);
      drain();

      if (mismatch_count == 0 && awaited_status.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/spf_pkg.sv
src/spf_channels.sv
src/stepper_position_follower.sv
test/tb.sv
